// ===== hw/rtl/lsbc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsbc_pkg
// Shared constants for the line segment box clipper: default widths and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package lsbc_pkg;

    localparam int DEF_COORD_WIDTH = 32;
    localparam int DEF_T_FRAC_BITS = 16;

    localparam int NUM_BOX_REGS = 6;
    localparam int REG_IDX_W    = 3;

    // Register indexes on the configuration port
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_X = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Y = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MIN_Z = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BOX_MAX_Z = 3'd5;

endpackage

// ===== hw/rtl/lsbc_div.sv =====
// ----------------------------------------------------------------------------
// lsbc_div
// Pipelined face quotient r = q / p in t format, one quotient bit per stage.
// Every stage advances only when en is high.
// ----------------------------------------------------------------------------
module lsbc_div #(
    parameter int COORD_WIDTH = 32,
    parameter int T_FRAC_BITS = 16
) (
    input  logic                           clk,
    input  logic                           en,
    input  logic signed [COORD_WIDTH:0]    q,
    input  logic signed [COORD_WIDTH:0]    p,
    output logic signed [T_FRAC_BITS+2:0]  r,
    output logic                           par,
    output logic                           par_rej,
    output logic                           enter
);
    import lsbc_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int F  = T_FRAC_BITS;
    localparam logic [F:0] TSAT = {1'b1, {(F-1){1'b0}}, 1'b1};

    logic [CW:0] rem_reg [0:F];
    logic [CW:0] pm_reg  [0:F];
    logic [F:0]  quo_reg [0:F];
    logic        sat_reg [0:F];
    logic        neg_reg [0:F];
    logic        par_reg [0:F];
    logic        rej_reg [0:F];
    logic        ent_reg [0:F];

    logic [CW:0]   qm;
    logic [CW:0]   pm;
    logic          sat;
    logic          ip;
    logic [CW:0]   rem0;
    logic [F:0]    mag;

    // Magnitudes, saturation check and integer bit
    always_comb
    begin
        qm   = q[CW] ? (CW+1)'(-q) : q;
        pm   = p[CW] ? (CW+1)'(-p) : p;
        sat  = {1'b0, qm} >= {pm, 1'b0};
        ip   = qm >= pm;
        rem0 = ip ? (qm - pm) : qm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0;
            pm_reg[0]  <= pm;
            quo_reg[0] <= {{F{1'b0}}, ip};
            sat_reg[0] <= sat;
            neg_reg[0] <= q[CW] != p[CW];
            par_reg[0] <= p == '0;
            rej_reg[0] <= q[CW];
            ent_reg[0] <= p[CW];
            // One restoring step per stage
            for (int k = 1; k <= F; k++)
            begin
                if ({rem_reg[k-1], 1'b0} >= {1'b0, pm_reg[k-1]})
                begin
                    rem_reg[k] <= (CW+1)'({rem_reg[k-1], 1'b0} - {1'b0, pm_reg[k-1]});
                    quo_reg[k] <= {quo_reg[k-1][F-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= (CW+1)'({rem_reg[k-1], 1'b0});
                    quo_reg[k] <= {quo_reg[k-1][F-1:0], 1'b0};
                end
                pm_reg[k]  <= pm_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
                par_reg[k] <= par_reg[k-1];
                rej_reg[k] <= rej_reg[k-1];
                ent_reg[k] <= ent_reg[k-1];
            end
        end
    end

    // Saturate and apply sign; a zero magnitude stays positive
    always_comb
    begin
        mag = (sat_reg[F] || quo_reg[F] > TSAT) ? TSAT : quo_reg[F];
        r   = (neg_reg[F] && mag != '0) ? -$signed({2'b00, mag}) : $signed({2'b00, mag});
    end

    assign par     = par_reg[F];
    assign par_rej = rej_reg[F];
    assign enter   = ent_reg[F];

endmodule

// ===== hw/rtl/line_segment_box_clipper_top.sv =====
// ----------------------------------------------------------------------------
// line_segment_box_clipper_top
// 3D Liang-Barsky clipping of a segment against an axis-aligned box.
//
// Usage:
//   Segments enter on the s_ stream (tdata, lowest bits first: start_x,
//   start_y, start_z, end_x, end_y, end_z). Results leave on the m_ stream,
//   tuser = visible, tdata = clip_start_x/y/z, clip_end_x/y/z.
//   The box is set through cfg_we / cfg_index / cfg_data while idle.
//   The six face dividers produce one quotient bit per stage. Throughput is
//   one segment per cycle while the receiver does not stall the pipeline.
//   The whole pipeline advances together; when the receiver holds m_tready
//   low with a result waiting, every stage holds and s_tready drops, so no
//   item is lost or repeated. Bubbles in the pipe travel without cost.
//   Reset empties the pipeline and sets the box to the full coordinate range
//   (each min most negative, each max most positive).
// ----------------------------------------------------------------------------
module line_segment_box_clipper_top #(
    parameter int COORD_WIDTH = lsbc_pkg::DEF_COORD_WIDTH,
    parameter int T_FRAC_BITS = lsbc_pkg::DEF_T_FRAC_BITS
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     s_tdata,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // clip_start_x, clip_start_y, clip_start_z, clip_end_x, clip_end_y, clip_end_z
    output logic [((6*COORD_WIDTH+7)/8)*8-1:0]     m_tdata,
    // visible
    output logic                                   m_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    input  logic                                   cfg_we,
    input  logic [lsbc_pkg::REG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]                 cfg_data
);
    import lsbc_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int F     = T_FRAC_BITS;
    localparam int OUT_W = ((6*CW+7)/8)*8;
    localparam int NV    = F + 6;
    localparam int ND    = F + 3;
    localparam logic signed [F+2:0] T_ONE_S = {2'b00, 1'b1, {F{1'b0}}};

    // Box registers
    logic [CW-1:0] box_reg [0:NUM_BOX_REGS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_BOX_REGS; i += 2)
            begin
                box_reg[i]   <= {1'b1, {(CW-1){1'b0}}};
                box_reg[i+1] <= {1'b0, {(CW-1){1'b1}}};
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOX_MIN_X: box_reg[0] <= cfg_data;
                REG_BOX_MAX_X: box_reg[1] <= cfg_data;
                REG_BOX_MIN_Y: box_reg[2] <= cfg_data;
                REG_BOX_MAX_Y: box_reg[3] <= cfg_data;
                REG_BOX_MIN_Z: box_reg[4] <= cfg_data;
                REG_BOX_MAX_Z: box_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic          en;
    logic [NV-1:0] vld_reg;

    assign en       = !vld_reg[NV-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
    end

    // Input stage: direction and face distances
    logic signed [CW-1:0] s_reg   [0:2];
    logic signed [CW:0]   d_reg   [0:2];
    logic signed [CW:0]   qlo_reg [0:2];
    logic signed [CW:0]   qhi_reg [0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s_reg[a]   <= $signed(s_tdata[a*CW +: CW]);
                d_reg[a]   <= $signed({s_tdata[(a+3)*CW+CW-1], s_tdata[(a+3)*CW +: CW]})
                            - $signed({s_tdata[a*CW+CW-1], s_tdata[a*CW +: CW]});
                qlo_reg[a] <= $signed({s_tdata[a*CW+CW-1], s_tdata[a*CW +: CW]})
                            - $signed({box_reg[2*a][CW-1], box_reg[2*a]});
                qhi_reg[a] <= $signed({box_reg[2*a+1][CW-1], box_reg[2*a+1]})
                            - $signed({s_tdata[a*CW+CW-1], s_tdata[a*CW +: CW]});
            end
        end
    end

    // Six face dividers: even = min face (p = -d), odd = max face (p = d)
    logic signed [F+2:0] r_face [0:5];
    logic                par_face [0:5];
    logic                rej_face [0:5];
    logic                ent_face [0:5];

    for (genvar g = 0; g < 6; g++)
    begin : g_face
        lsbc_div #(
            .COORD_WIDTH (CW),
            .T_FRAC_BITS (F)
        ) u_div (
            .clk     (clk),
            .en      (en),
            .q       ((g % 2 == 0) ? qlo_reg[g/2] : qhi_reg[g/2]),
            .p       ((g % 2 == 0) ? (CW+1)'(-d_reg[g/2]) : d_reg[g/2]),
            .r       (r_face[g]),
            .par     (par_face[g]),
            .par_rej (rej_face[g]),
            .enter   (ent_face[g])
        );
    end

    // Delay line for start point and direction, aligned with the offset computation
    logic signed [CW-1:0] sdl_reg [0:ND-1][0:2];
    logic signed [CW:0]   ddl_reg [0:ND-1][0:2];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sdl_reg[0][a] <= s_reg[a];
                ddl_reg[0][a] <= d_reg[a];
                for (int k = 1; k < ND; k++)
                begin
                    sdl_reg[k][a] <= sdl_reg[k-1][a];
                    ddl_reg[k][a] <= ddl_reg[k-1][a];
                end
            end
        end
    end

    // Reduce: t0 = max of entering quotients, t1 = min of leaving quotients
    logic signed [F+2:0] t0_next;
    logic signed [F+2:0] t1_next;
    logic                rej_next;
    logic signed [F+2:0] t0_reg;
    logic signed [F+2:0] t1_reg;
    logic                rej_reg;

    always_comb
    begin
        t0_next  = '0;
        t1_next  = T_ONE_S;
        rej_next = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            if (par_face[i])
                rej_next = rej_next | rej_face[i];
            else if (ent_face[i])
            begin
                if (r_face[i] > t0_next)
                    t0_next = r_face[i];
            end
            else
            begin
                if (r_face[i] < t1_next)
                    t1_next = r_face[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg  <= t0_next;
            t1_reg  <= t1_next;
            rej_reg <= rej_next;
        end
    end

    // Visibility decision
    logic        vis_reg;
    logic [F:0]  t0u_reg;
    logic [F:0]  t1u_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vis_reg <= !rej_reg && (t0_reg <= t1_reg);
            t0u_reg <= t0_reg[F:0];
            t1u_reg <= t1_reg[F:0];
        end
    end

    // Offsets |d| * t, truncated
    logic [CW-1:0]        off0_reg [0:2];
    logic [CW-1:0]        off1_reg [0:2];
    logic                 dneg_reg [0:2];
    logic signed [CW-1:0] sm_reg   [0:2];
    logic                 vism_reg;
    logic [CW-1:0]        dmag     [0:2];
    logic [CW+F:0]        prod0    [0:2];
    logic [CW+F:0]        prod1    [0:2];

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            dmag[a]  = ddl_reg[ND-1][a][CW] ? CW'(-ddl_reg[ND-1][a])
                                            : CW'(ddl_reg[ND-1][a]);
            prod0[a] = (CW+F+1)'(dmag[a]) * (CW+F+1)'(t0u_reg);
            prod1[a] = (CW+F+1)'(dmag[a]) * (CW+F+1)'(t1u_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                off0_reg[a] <= prod0[a][CW+F-1:F];
                off1_reg[a] <= prod1[a][CW+F-1:F];
                dneg_reg[a] <= ddl_reg[ND-1][a][CW];
                sm_reg[a]   <= sdl_reg[ND-1][a];
            end
            vism_reg <= vis_reg;
        end
    end

    // Clipped endpoints; zero when rejected
    logic [6*CW-1:0] out_data_reg;
    logic            out_vis_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int a = 0; a < 3; a++)
            begin
                if (!vism_reg)
                begin
                    out_data_reg[a*CW +: CW]     <= '0;
                    out_data_reg[(a+3)*CW +: CW] <= '0;
                end
                else if (dneg_reg[a])
                begin
                    out_data_reg[a*CW +: CW]     <= sm_reg[a] - off0_reg[a];
                    out_data_reg[(a+3)*CW +: CW] <= sm_reg[a] - off1_reg[a];
                end
                else
                begin
                    out_data_reg[a*CW +: CW]     <= sm_reg[a] + off0_reg[a];
                    out_data_reg[(a+3)*CW +: CW] <= sm_reg[a] + off1_reg[a];
                end
            end
            out_vis_reg <= vism_reg;
        end
    end

    assign m_tdata = OUT_W'(out_data_reg);
    assign m_tuser = out_vis_reg;

    // Checks
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> out_data_reg == '0)
        else $error("rejected segment with nonzero coordinates");

    a_last_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en && vld_reg[NV-2] |=> m_tvalid)
        else $error("item lost between last two stages");

    a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved during stall");

endmodule

// ===== bench/line_segment_box_clipper_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// line_segment_box_clipper_top_tb
// Streams 3D segments through the box clipper under several box settings and
// compares every clipped result against a bit-exact Liang-Barsky predictor,
// with random idling on both streams and one long output stall.
// ----------------------------------------------------------------------------
module line_segment_box_clipper_top_tb;
    import lsbc_pkg::*;

    localparam int CW   = DEF_COORD_WIDTH;
    localparam int TF   = DEF_T_FRAC_BITS;
    localparam int DW   = ((6*CW+7)/8)*8;
    localparam int LAT  = TF + 6;
    localparam int IDLE_LIMIT = 4000;

    typedef logic signed [CW-1:0] coord_t;
    typedef struct packed {
        logic   vis;
        logic [DW-1:0] data;
    } clip_res_t;

    logic clk = 0, rst_n = 0;
    logic [DW-1:0] s_tdata = '0;
    logic s_tvalid = 0, s_tready;
    logic [DW-1:0] m_tdata;
    logic m_tuser, m_tvalid;
    logic m_tready = 0;
    logic cfg_we = 0;
    logic [REG_IDX_W-1:0] cfg_index = '0;
    logic [CW-1:0] cfg_data = '0;

    int errors = 0;
    int seg_count = 0, res_count = 0, vis_count = 0;
    bit stall_long = 0;
    int idle_cycles = 0;

    line_segment_box_clipper_top DUT (.*);

    always
    begin
        #4 clk = 1;
        #4 clk = 0;
    end

    // Box registers as the predictor sees them
    coord_t box_q [6];

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %h want %h (result %0d)", what, got, want, res_count);
        errors++;
    endtask

    // floor(qm * 2^TF / pm) saturated at 1.0 + 1 LSB
    function automatic logic [63:0] ratio_mag(input logic [63:0] qm, input logic [63:0] pm);
        logic [127:0] n;
        logic [127:0] r;
        n = {64'd0, qm} << TF;
        r = n / pm;
        if (r > (128'd1 << TF) + 1) r = (128'd1 << TF) + 1;
        return r[63:0];
    endfunction

    function automatic bit face_ok(input longint p, input longint q,
                                   inout longint t0, inout longint t1);
        logic [63:0] rm;
        longint r;
        if (p == 0) return q >= 0;
        rm = ratio_mag(q < 0 ? -q : q, p < 0 ? -p : p);
        r = longint'(rm);
        if (rm != 0 && ((p < 0) != (q < 0))) r = -r;
        if (p < 0)
        begin
            if (r > t1) return 0;
            if (r > t0) t0 = r;
        end
        else
        begin
            if (r < t0) return 0;
            if (r < t1) t1 = r;
        end
        return 1;
    endfunction

    function automatic longint interp(input longint s, input longint d, input longint t);
        logic [127:0] prod;
        longint off;
        prod = 128'(d < 0 ? -d : d) * 128'(t);
        off = longint'(prod >> TF);
        return d < 0 ? s - off : s + off;
    endfunction

    function automatic clip_res_t clip_segment(input logic [DW-1:0] seg);
        longint s[3], e[3], lo[3], hi[3], d[3], cs[3], ce[3];
        longint t0, t1;
        bit vis, in_box;
        clip_res_t res;
        t0 = 0;
        t1 = longint'(1) << TF;
        vis = 1;
        in_box = 1;
        for (int a = 0; a < 3; a++)
        begin
            s[a] = longint'(coord_t'(seg[a*CW +: CW]));
            e[a] = longint'(coord_t'(seg[(3+a)*CW +: CW]));
            lo[a] = longint'(box_q[2*a]);
            hi[a] = longint'(box_q[2*a+1]);
            d[a] = e[a] - s[a];
            if (s[a] < lo[a] || s[a] > hi[a] || e[a] < lo[a] || e[a] > hi[a]) in_box = 0;
        end
        if (in_box)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cs[a] = s[a];
                ce[a] = e[a];
            end
        end
        else
        begin
            for (int a = 0; a < 3 && vis; a++)
                if (!face_ok(-d[a], s[a] - lo[a], t0, t1) ||
                    !face_ok(d[a], hi[a] - s[a], t0, t1))
                    vis = 0;
            for (int a = 0; a < 3; a++)
            begin
                cs[a] = vis ? interp(s[a], d[a], t0) : 0;
                ce[a] = vis ? interp(s[a], d[a], t1) : 0;
            end
        end
        res.vis = vis;
        res.data = '0;
        for (int a = 0; a < 3; a++)
        begin
            res.data[a*CW +: CW] = cs[a][CW-1:0];
            res.data[(3+a)*CW +: CW] = ce[a][CW-1:0];
        end
        return res;
    endfunction

    // Holds the clips still owed by the block, oldest first
    class clip_scoreboard;
        clip_res_t owed[$];

        function void note_segment(logic [DW-1:0] seg);
            owed.push_back(clip_segment(seg));
        endfunction

        task check_clip(logic vis, logic [DW-1:0] data);
            clip_res_t want;
            if (owed.size() == 0)
            begin
                report("unexpected result", {63'd0, vis}, 64'd0);
                return;
            end
            want = owed.pop_front();
            if (vis !== want.vis) report("visible", {63'd0, vis}, {63'd0, want.vis});
            for (int f = 0; f < 6; f++)
                if (data[f*CW +: CW] !== want.data[f*CW +: CW])
                    report($sformatf("field %0d", f), 64'(data[f*CW +: CW]),
                           64'(want.data[f*CW +: CW]));
        endtask
    endclass

    clip_scoreboard board = new();

    task automatic write_box(input logic [REG_IDX_W-1:0] idx, input coord_t v);
        @(negedge clk);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 0;
        if (idx < NUM_BOX_REGS) box_q[idx] = v;
    endtask

    task automatic set_box(input coord_t x0, x1, y0, y1, z0, z1);
        write_box(REG_BOX_MIN_X, x0);
        write_box(REG_BOX_MAX_X, x1);
        write_box(REG_BOX_MIN_Y, y0);
        write_box(REG_BOX_MAX_Y, y1);
        write_box(REG_BOX_MIN_Z, z0);
        write_box(REG_BOX_MAX_Z, z1);
    endtask

    // Offer one segment, after a random gap when gaps is set; hold until accepted
    task automatic send_segment(input logic [DW-1:0] seg, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 14) : 0;
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) @(negedge clk);
        s_tvalid = 1;
        s_tdata = seg;
        do @(posedge clk); while (!s_tready);
        board.note_segment(seg);
        seg_count++;
        @(negedge clk);
        s_tvalid = 0;
    endtask

    function automatic logic [DW-1:0] pack_seg(input coord_t sx, sy, sz, ex, ey, ez);
        logic [DW-1:0] v;
        v = '0;
        v[0*CW +: CW] = sx; v[1*CW +: CW] = sy; v[2*CW +: CW] = sz;
        v[3*CW +: CW] = ex; v[4*CW +: CW] = ey; v[5*CW +: CW] = ez;
        return v;
    endfunction

    // Coordinate near the box: mostly inside or a little outside, sometimes extreme
    function automatic coord_t near_box(input int axis);
        longint lo, hi, span;
        lo = box_q[2*axis];
        hi = box_q[2*axis+1];
        case ($urandom_range(0, 9))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? coord_t'(lo) : coord_t'(hi);
            2: return $urandom_range(0, 1) ? {1'b1, {CW-1{1'b0}}} : {1'b0, {CW-1{1'b1}}};
            default:
            begin
                span = (hi > lo) ? hi - lo : 64'd1 << 20;
                return coord_t'(lo - span/4 +
                       longint'({$urandom, $urandom} % 64'(span + span/2 + 1)));
            end
        endcase
    endfunction

    task automatic drain;
        while (board.owed.size() != 0) @(negedge clk);
        repeat (LAT + 4) @(negedge clk);
    endtask

    task automatic random_phase(input int n);
        coord_t s[3], e[3];
        for (int i = 0; i < n; i++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                s[a] = near_box(a);
                e[a] = ($urandom_range(0, 15) == 0) ? s[a] : near_box(a);
            end
            if ($urandom_range(0, 19) == 0) e = s;
            send_segment(pack_seg(s[0], s[1], s[2], e[0], e[1], e[2]), i % 200 < 150);
        end
    endtask

    // Receiver: random ready gaps, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_long)
            begin
                m_tready = 0;
                repeat (300) @(negedge clk);
                stall_long = 0;
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
            m_tready = 0;
            repeat (gap) @(negedge clk);
            m_tready = 1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // Check results and watch for a stuck run
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            board.check_clip(m_tuser, m_tdata);
            res_count++;
            if (m_tuser) vis_count++;
        end
        if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we || !rst_n ||
            (board.owed.size() == 0 && !s_tvalid))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    localparam coord_t CMIN = {1'b1, {CW-1{1'b0}}};
    localparam coord_t CMAX = {1'b0, {CW-1{1'b1}}};

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            box_q[2*a] = CMIN;
            box_q[2*a+1] = CMAX;
        end
        repeat (4) @(negedge clk);
        rst_n = 1;

        // Reset box: everything inside, extremes pass through
        send_segment(pack_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 0);
        send_segment(pack_seg(CMAX, CMIN, 0, CMIN, CMAX, -1), 0);
        drain();

        // Unit box, directed cases
        set_box(-32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000, -32'sh10000, 32'sh10000);
        send_segment(pack_seg(0, 0, 0, 32'sh8000, 32'sh8000, 0), 0);           // inside
        send_segment(pack_seg(-32'sh30000, 0, 0, 32'sh30000, 0, 0), 0);        // crosses x
        send_segment(pack_seg(0, -32'sh30000, 0, 0, 32'sh30000, 0), 0);        // crosses y
        send_segment(pack_seg(0, 0, 32'sh30000, 0, 0, -32'sh30000), 0);        // crosses z
        send_segment(pack_seg(32'sh20000, 0, 0, 32'sh20000, 32'sh5000, 0), 0); // parallel out
        send_segment(pack_seg(32'sh20000, 5, 7, 32'sh20000, 5, 7), 0);         // point out
        send_segment(pack_seg(32'sh10000, 32'sh10000, 32'sh10000,
                              -32'sh10000, -32'sh10000, -32'sh10000), 0);      // faces
        send_segment(pack_seg(32'sh20000, 32'sh20000, 0, 32'sh30000, 0, 0), 0); // miss corner
        send_segment(pack_seg(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX), 0);
        send_segment(pack_seg(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN), 0);
        send_segment(pack_seg(-32'sh20000, 32'sh20000, 0, 32'sh20000, -32'sh20000, 3), 0);
        drain();

        // Inverted box on x
        set_box(32'sh10000, -32'sh10000, CMIN, CMAX, CMIN, CMAX);
        send_segment(pack_seg(0, 0, 0, 32'sh1000, 0, 0), 0);
        send_segment(pack_seg(-32'sh30000, 1, 2, 32'sh30000, 3, 4), 0);
        send_segment(pack_seg(0, 1, 2, 0, 9, 9), 0);
        drain();

        // Out-of-range index must be ignored
        write_box(3'd6, 32'sh0);
        write_box(3'd7, 32'sh0);

        // Random phases over several boxes; one long output stall early on
        set_box(-32'sh40000, 32'sh40000, -32'sh20000, 32'sh60000, -32'sh100, 32'sh100);
        stall_long = 1;
        random_phase(300);
        drain();
        set_box(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX);
        random_phase(200);
        drain();
        set_box(-32'sh1000_0000, 32'sh1000_0000, 32'sh0, 32'sh0, CMIN, 32'sh1);
        random_phase(200);
        drain();
        set_box(coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
                coord_t'($urandom), coord_t'($urandom), coord_t'($urandom));
        random_phase(150);
        drain();
        set_box(CMAX, CMIN, -32'sh8000, 32'sh8000, CMIN, CMAX);
        random_phase(100);
        drain();
        set_box(-32'sh50000, 32'sh30000, -32'sh50000, 32'sh30000, -32'sh50000, 32'sh30000);
        random_phase(180);
        drain();

        $display("covered %0d segments, %0d results (%0d visible), %0d mismatches",
                 seg_count, res_count, vis_count, errors);
        $display("boxes: reset, unit, inverted, full range, flat, random, tight");
        if (errors == 0 && board.owed.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
